FILE: hw/rtl/zohr_pkg.sv
// Shared constants, types and controller/datapath interface structs for the resampler.
package zohr_pkg;

  localparam int MAX_CHANNELS = 4;
  localparam int SAMPLE_BITS  = 24;

  localparam int STEP_BITS = 23;
  localparam int ACT_BITS  = 3;
  localparam int POS_BITS  = 23;
  localparam int FRAC_BITS = 16;
  localparam int IDX_BITS  = 1;

  localparam logic [POS_BITS-1:0]  ONE_Q16    = POS_BITS'(65536);
  localparam logic [STEP_BITS-1:0] STEP_LOW   = STEP_BITS'(1024);
  localparam logic [STEP_BITS-1:0] STEP_HIGH  = STEP_BITS'(4194304);
  localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(65536);
  localparam logic [ACT_BITS-1:0]  ACT_RESET  = ACT_BITS'(1);
  localparam logic [ACT_BITS-1:0]  ACT_MAX    = ACT_BITS'(MAX_CHANNELS);

  // register indexes on the configuration port
  localparam logic [IDX_BITS-1:0] REG_STEP_SIZE       = IDX_BITS'(0);
  localparam logic [IDX_BITS-1:0] REG_ACTIVE_CHANNELS = IDX_BITS'(1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t [MAX_CHANNELS-1:0]    frame_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  typedef struct packed {
    logic capture;  // take the incoming frame
    logic emit;     // load one output frame and advance the position
    logic finish;   // drop one from the position and hold the new frame
  } dp_cmd_t;

  typedef struct packed {
    logic below_one;  // read position is below one
    logic out_free;   // output register can take a frame this cycle
  } dp_status_t;

endpackage

FILE: hw/rtl/zero_order_hold_resampler.sv
// Top level of the zero-order-hold resampler: controller plus datapath.
//
//   transaction   handshake               payload
//   ------------  ----------------------  -------------------------------------
//   input frame   in_valid / in_stall     sample_0 .. sample_3
//   output frame  out_valid / out_stall   out_0 .. out_3, last_of_run
//   config write  cfg_write_en            cfg_index, cfg_data
//
// An input frame is taken in a capture step, then causes N output frames
// (0 to 64), each through the shared position adder, and ends with a step
// that wraps the position. Reset (rst, synchronous) restores step 1.0, one
// channel, position zero and the unprimed state. A stall on the output holds
// the emission loop; the output register lets the next input frame be taken
// while the last output frame still waits.
module zero_order_hold_resampler
  import zohr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_write_en,
  input  logic [IDX_BITS-1:0]  cfg_index,
  input  logic [STEP_BITS-1:0] cfg_data,
  // input frames
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sample_t              sample_0,
  input  sample_t              sample_1,
  input  sample_t              sample_2,
  input  sample_t              sample_3,
  // output frames
  output logic                 out_valid,
  input  logic                 out_stall,
  output sample_t              out_0,
  output sample_t              out_1,
  output sample_t              out_2,
  output sample_t              out_3,
  output logic                 last_of_run
);

  dp_cmd_t    cmd;
  dp_status_t status;
  frame_t     in_frame;
  frame_t     out_frame;

  // gather the channel ports into one frame
  assign in_frame[0] = sample_0;
  assign in_frame[1] = sample_1;
  assign in_frame[2] = sample_2;
  assign in_frame[3] = sample_3;

  assign out_0 = out_frame[0];
  assign out_1 = out_frame[1];
  assign out_2 = out_frame[2];
  assign out_3 = out_frame[3];

  // sequence one input frame at a time
  zohr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // hold frames, advance the read position, register the output
  zohr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_frame     (in_frame),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_frame    (out_frame),
    .out_last     (last_of_run)
  );

endmodule

FILE: hw/rtl/zohr_ctrl.sv
// Controller state machine: sequences capture, emission and wrap-up of one frame.
module zohr_ctrl
  import zohr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status.below_one) begin
          cmd.emit = status.out_free;
        end else begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: hw/rtl/zohr_dp.sv
// Datapath: configuration registers, frame stores, read position and output register.
module zohr_dp
  import zohr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [IDX_BITS-1:0]  cfg_index,
  input  logic [STEP_BITS-1:0] cfg_data,
  input  frame_t               in_frame,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output frame_t               out_frame,
  output logic                 out_last
);

  logic [STEP_BITS-1:0] step_size;
  logic [ACT_BITS-1:0]  active_channels;
  logic [STEP_BITS-1:0] step_clamped;
  logic [ACT_BITS-1:0]  act_clamped;
  frame_t               held;
  frame_t               pending;
  frame_t               masked;
  logic                 primed;
  logic [POS_BITS-1:0]  read_position;
  logic [POS_BITS-1:0]  pos_sum;

  // clamp register writes to the legal range
  always_comb begin
    step_clamped = cfg_data;
    if (cfg_data < STEP_LOW) begin
      step_clamped = STEP_LOW;
    end else if (cfg_data > STEP_HIGH) begin
      step_clamped = STEP_HIGH;
    end
    act_clamped = cfg_data[ACT_BITS-1:0];
    if (act_clamped == '0) begin
      act_clamped = ACT_RESET;
    end else if (act_clamped > ACT_MAX) begin
      act_clamped = ACT_MAX;
    end
  end

  // lanes at or above the channel count read as zero
  always_comb begin
    for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
      masked[ch] = (ACT_BITS'(ch) < active_channels) ? held[ch] : '0;
    end
  end

  assign pos_sum          = read_position + POS_BITS'(step_size);
  assign status.below_one = (read_position[POS_BITS-1:FRAC_BITS] == '0);
  assign status.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size       <= STEP_RESET;
      active_channels <= ACT_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_STEP_SIZE:       step_size       <= step_clamped;
        REG_ACTIVE_CHANNELS: active_channels <= act_clamped;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed        <= 1'b0;
      read_position <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.capture) begin
        primed <= 1'b1;
      end
      if (cmd.emit) begin
        read_position <= pos_sum;
        out_valid     <= 1'b1;
      end else if (cmd.finish) begin
        read_position <= read_position - ONE_Q16;
      end
      if (!cmd.emit && out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pending <= in_frame;
      if (!primed) begin
        held <= in_frame;
      end
    end
    if (cmd.finish) begin
      held <= pending;
    end
    if (cmd.emit) begin
      out_frame <= masked;
      out_last  <= (pos_sum[POS_BITS-1:FRAC_BITS] != '0);
    end
  end

endmodule
